[design/ebgq_pkg.sv]
// ----------------------------------------------------------------------------
// ebgq_pkg: shared types and constants of the encoder/button gesture qualifier
// Event codes, register indexes, reset values and the quadrature step table.
// ----------------------------------------------------------------------------
package ebgq_pkg;

  // default width of the tick counter and all stored times
  localparam int TIME_WIDTH_DEFAULT = 32;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // register indexes
  typedef enum logic [2:0] {
    REG_DETENT_STEPS   = 3'd0,
    REG_BUTTON_LOCKOUT = 3'd1,
    REG_VIB_LOCKOUT    = 3'd2,
    REG_LONG_PRESS     = 3'd3,
    REG_CLICK_INTERVAL = 3'd4,
    REG_VIB_WINDOW     = 3'd5,
    REG_VIB_COUNT      = 3'd6
  } reg_index_t;

  // register reset values
  localparam logic [2:0]  RST_DETENT_STEPS   = 3'd4;
  localparam logic [31:0] RST_BUTTON_LOCKOUT = 32'd300000;
  localparam logic [31:0] RST_VIB_LOCKOUT    = 32'd50000;
  localparam logic [31:0] RST_LONG_PRESS     = 32'd1000000;
  localparam logic [31:0] RST_CLICK_INTERVAL = 32'd500000;
  localparam logic [31:0] RST_VIB_WINDOW     = 32'd1000000;
  localparam logic [3:0]  RST_VIB_COUNT      = 4'd3;

  // result event codes
  typedef enum logic [2:0] {
    EV_ROTATE  = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_TRIPLE  = 3'd4,
    EV_VIB     = 3'd5
  } event_kind_t;

  // positions in the per-tick event mask, in delivery order
  localparam int EVB_ROTATE  = 0;
  localparam int EVB_PRESS   = 1;
  localparam int EVB_TRIPLE  = 2;
  localparam int EVB_RELEASE = 3;
  localparam int EVB_LONG    = 4;
  localparam int EVB_VIB     = 5;
  localparam int EV_BITS     = 6;

  typedef logic [EV_BITS-1:0] ev_mask_t;

  // quadrature step for {prev_a, prev_b, cur_a, cur_b}
  function automatic logic signed [3:0] quad_step(input logic [3:0] idx);
    logic signed [3:0] r;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: r = -4'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: r = 4'sd1;
      default: r = 4'sd0;
    endcase
    return r;
  endfunction

endpackage

[design/ebgq_if.sv]
// ----------------------------------------------------------------------------
// ebgq_if: stream channels of the gesture qualifier
// Input tick channel and output event channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ebgq_in_if;
  logic valid;
  logic ready;
  logic phase_a;
  logic phase_b;
  logic button_level;
  logic vibration_level;

  modport source (output valid, phase_a, phase_b, button_level, vibration_level,
                  input ready);
  modport sink (input valid, phase_a, phase_b, button_level, vibration_level,
                output ready);
endinterface

interface ebgq_out_if;
  logic                  valid;
  logic                  ready;
  ebgq_pkg::event_kind_t event_kind;
  logic signed [1:0]     rotate_step;
  logic                  last_of_tick;

  modport source (output valid, event_kind, rotate_step, last_of_tick,
                  input ready);
  modport sink (input valid, event_kind, rotate_step, last_of_tick,
                output ready);
endinterface

[design/encoder_button_gesture_qualifier.sv]
// ----------------------------------------------------------------------------
// encoder_button_gesture_qualifier: rotary encoder, button and vibration events
// Each input word is one tick of sampled pins. The block decodes quadrature
// steps into detent rotate events, qualifies button presses (with triple
// click, release and long press) and vibration triggers, and emits the events
// of each tick in order, the last one flagged. A tick is taken every clock while
// the waiting slot is free: all decoding is one pass of compares and adds from the
// state registers into a two-deep event buffer. The events of a tick leave the
// drain slot one word at a time, and input stalls only when both buffer slots
// are occupied. No clearing pass after reset.
// ----------------------------------------------------------------------------
module encoder_button_gesture_qualifier #(
  parameter int TIME_WIDTH = ebgq_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  ebgq_in_if.sink                         in_ch,
  ebgq_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ebgq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ebgq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ebgq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int CMP_W = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  typedef logic [TIME_WIDTH-1:0] time_t;

  function automatic logic [CMP_W-1:0] elapsed(input time_t now, input time_t then);
    time_t d;
    d = now - then;
    return CMP_W'(d);
  endfunction

  // configuration registers
  logic [2:0]  detent_steps;
  logic [31:0] button_lockout_ticks;
  logic [31:0] vibration_lockout_ticks;
  logic [31:0] long_press_ticks;
  logic [31:0] click_interval_ticks;
  logic [31:0] vibration_window_ticks;
  logic [3:0]  vibration_count_needed;

  logic       cfg_wr;
  logic [2:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      detent_steps            <= ebgq_pkg::RST_DETENT_STEPS;
      button_lockout_ticks    <= ebgq_pkg::RST_BUTTON_LOCKOUT;
      vibration_lockout_ticks <= ebgq_pkg::RST_VIB_LOCKOUT;
      long_press_ticks        <= ebgq_pkg::RST_LONG_PRESS;
      click_interval_ticks    <= ebgq_pkg::RST_CLICK_INTERVAL;
      vibration_window_ticks  <= ebgq_pkg::RST_VIB_WINDOW;
      vibration_count_needed  <= ebgq_pkg::RST_VIB_COUNT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ebgq_pkg::REG_DETENT_STEPS:   detent_steps            <= pwdata[2:0];
        ebgq_pkg::REG_BUTTON_LOCKOUT: button_lockout_ticks    <= pwdata;
        ebgq_pkg::REG_VIB_LOCKOUT:    vibration_lockout_ticks <= pwdata;
        ebgq_pkg::REG_LONG_PRESS:     long_press_ticks        <= pwdata;
        ebgq_pkg::REG_CLICK_INTERVAL: click_interval_ticks    <= pwdata;
        ebgq_pkg::REG_VIB_WINDOW:     vibration_window_ticks  <= pwdata;
        ebgq_pkg::REG_VIB_COUNT:      vibration_count_needed  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      ebgq_pkg::REG_DETENT_STEPS:   prdata = {29'd0, detent_steps};
      ebgq_pkg::REG_BUTTON_LOCKOUT: prdata = button_lockout_ticks;
      ebgq_pkg::REG_VIB_LOCKOUT:    prdata = vibration_lockout_ticks;
      ebgq_pkg::REG_LONG_PRESS:     prdata = long_press_ticks;
      ebgq_pkg::REG_CLICK_INTERVAL: prdata = click_interval_ticks;
      ebgq_pkg::REG_VIB_WINDOW:     prdata = vibration_window_ticks;
      ebgq_pkg::REG_VIB_COUNT:      prdata = {28'd0, vibration_count_needed};
      default:                      prdata = '0;
    endcase
  end

  // tick state
  logic [1:0]        prev_phase;
  logic signed [3:0] detent_accum;
  time_t             tick_count;
  logic              prev_button_level;
  time_t             button_accept_time;
  logic              button_held;
  time_t             press_start_time;
  logic              long_reported;
  time_t             last_click_time;
  logic [1:0]        click_count;
  logic              prev_vibration_level;
  time_t             vibration_accept_time;
  time_t             window_start_time;
  logic [3:0]        vibration_count;

  // event buffer: slot being drained and one waiting slot
  ebgq_pkg::ev_mask_t out_mask;
  logic               out_neg;
  logic               out_busy;
  ebgq_pkg::ev_mask_t hold_mask;
  logic               hold_neg;
  logic               hold_valid;

  logic in_fire;
  assign in_ch.ready = ~hold_valid;
  assign in_fire     = in_ch.valid & in_ch.ready;

  // encoder decode
  logic [1:0]        cur_phase;
  logic signed [3:0] accum_sum;
  logic signed [3:0] det_eff;
  logic              rot_neg;
  logic              rot_pos;
  logic signed [3:0] detent_accum_next;

  assign cur_phase = {in_ch.phase_a, in_ch.phase_b};
  assign accum_sum = detent_accum + ebgq_pkg::quad_step({prev_phase, cur_phase});
  assign det_eff   = (detent_steps == 3'd0) ? 4'sd1 : $signed({1'b0, detent_steps});
  assign rot_neg   = accum_sum >= det_eff;
  assign rot_pos   = accum_sum <= -det_eff;
  assign detent_accum_next = (rot_neg | rot_pos) ? 4'sd0 : accum_sum;

  // button press, triple click, release, long press
  logic       press;
  logic       in_interval;
  logic [1:0] click_inc;
  logic       triple;
  logic [1:0] click_count_next;
  logic       held_mid;
  logic       release_ev;
  logic       button_held_next;
  time_t      press_start_time_next;
  logic       long_mid;
  logic       long_ev;

  assign press = prev_button_level & ~in_ch.button_level &
                 (elapsed(tick_count, button_accept_time) >= CMP_W'(button_lockout_ticks));
  assign in_interval = elapsed(tick_count, last_click_time) < CMP_W'(click_interval_ticks);
  assign click_inc   = click_count + 2'd1;
  assign triple      = press & in_interval & (click_inc == 2'd3);

  always_comb begin
    click_count_next = click_count;
    if (press) begin
      if (!in_interval) begin
        click_count_next = 2'd1;
      end else if (triple) begin
        click_count_next = 2'd0;
      end else begin
        click_count_next = click_inc;
      end
    end
  end

  assign held_mid              = press | button_held;
  assign release_ev            = held_mid & in_ch.button_level;
  assign button_held_next      = held_mid & ~in_ch.button_level;
  assign press_start_time_next = press ? tick_count : press_start_time;
  assign long_mid              = press ? 1'b0 : long_reported;
  // a fresh press has zero hold time so far
  assign long_ev = button_held_next & ~long_mid &
                   (press ? (long_press_ticks == 32'd0) :
                    (elapsed(tick_count, press_start_time) >= CMP_W'(long_press_ticks)));

  // vibration trigger counting
  logic       vib_trig;
  logic       win_expired;
  logic [3:0] vib_need;
  logic [3:0] vib_cnt_mid;
  logic       vib_ev;
  logic [3:0] vibration_count_next;
  logic       new_window;

  assign vib_trig = prev_vibration_level & ~in_ch.vibration_level &
                    (elapsed(tick_count, vibration_accept_time) >=
                     CMP_W'(vibration_lockout_ticks));
  assign win_expired = (vibration_count != 4'd0) &
                       (elapsed(tick_count, window_start_time) >
                        CMP_W'(vibration_window_ticks));
  assign new_window  = (vibration_count == 4'd0) | win_expired;
  assign vib_need    = (vibration_count_needed == 4'd0) ? 4'd1 : vibration_count_needed;
  assign vib_cnt_mid = new_window ? 4'd1 : vibration_count + 4'd1;
  assign vib_ev      = vib_trig & (vib_cnt_mid >= vib_need);

  always_comb begin
    vibration_count_next = vibration_count;
    if (vib_trig) begin
      vibration_count_next = vib_ev ? 4'd0 : vib_cnt_mid;
    end
  end

  // events of this tick in delivery order
  ebgq_pkg::ev_mask_t ev_mask;
  always_comb begin
    ev_mask = '0;
    ev_mask[ebgq_pkg::EVB_ROTATE]  = rot_neg | rot_pos;
    ev_mask[ebgq_pkg::EVB_PRESS]   = press;
    ev_mask[ebgq_pkg::EVB_TRIPLE]  = triple;
    ev_mask[ebgq_pkg::EVB_RELEASE] = release_ev;
    ev_mask[ebgq_pkg::EVB_LONG]    = long_ev;
    ev_mask[ebgq_pkg::EVB_VIB]     = vib_ev;
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase            <= 2'd3;
      detent_accum          <= 4'sd0;
      tick_count            <= '0;
      prev_button_level     <= 1'b1;
      button_accept_time    <= '0;
      button_held           <= 1'b0;
      press_start_time      <= '0;
      long_reported         <= 1'b0;
      last_click_time       <= '0;
      click_count           <= 2'd0;
      prev_vibration_level  <= 1'b1;
      vibration_accept_time <= '0;
      window_start_time     <= '0;
      vibration_count       <= 4'd0;
    end else if (in_fire) begin
      prev_phase           <= cur_phase;
      detent_accum         <= detent_accum_next;
      tick_count           <= tick_count + 1'b1;
      prev_button_level    <= in_ch.button_level;
      button_held          <= button_held_next;
      press_start_time     <= press_start_time_next;
      long_reported        <= long_mid | long_ev;
      click_count          <= click_count_next;
      prev_vibration_level <= in_ch.vibration_level;
      vibration_count      <= vibration_count_next;
      if (press) begin
        button_accept_time <= tick_count;
        last_click_time    <= tick_count;
      end
      if (vib_trig) begin
        vibration_accept_time <= tick_count;
        if (new_window) begin
          window_start_time <= tick_count;
        end
      end
    end
  end

  // output selection: lowest pending event of the drained slot
  ebgq_pkg::ev_mask_t low_bit;
  ebgq_pkg::ev_mask_t rem_mask;
  logic               out_fire;
  logic               out_done;
  logic               out_free;
  logic               new_item;

  assign low_bit  = out_mask & (~out_mask + 1'b1);
  assign rem_mask = out_mask & ~low_bit;
  assign out_fire = out_ch.valid & out_ch.ready;
  assign out_done = out_fire & (rem_mask == '0);
  assign out_free = ~out_busy | out_done;
  assign new_item = in_fire & (ev_mask != '0);

  assign out_ch.valid        = out_busy;
  assign out_ch.last_of_tick = rem_mask == '0;

  always_comb begin
    out_ch.event_kind  = ebgq_pkg::EV_ROTATE;
    out_ch.rotate_step = 2'sd0;
    case (low_bit)
      6'b000001: begin
        out_ch.event_kind  = ebgq_pkg::EV_ROTATE;
        out_ch.rotate_step = out_neg ? -2'sd1 : 2'sd1;
      end
      6'b000010: out_ch.event_kind = ebgq_pkg::EV_PRESS;
      6'b000100: out_ch.event_kind = ebgq_pkg::EV_TRIPLE;
      6'b001000: out_ch.event_kind = ebgq_pkg::EV_RELEASE;
      6'b010000: out_ch.event_kind = ebgq_pkg::EV_LONG;
      6'b100000: out_ch.event_kind = ebgq_pkg::EV_VIB;
      default: ;
    endcase
  end

  // buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy   <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_busy   <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        out_busy <= new_item;
      end
    end else if (new_item) begin
      hold_valid <= 1'b1;
    end
  end

  // buffer payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) begin
        out_mask <= hold_mask;
        out_neg  <= hold_neg;
      end else begin
        out_mask <= ev_mask;
        out_neg  <= rot_neg;
      end
    end else begin
      if (out_fire) begin
        out_mask <= rem_mask;
      end
      if (new_item) begin
        hold_mask <= ev_mask;
        hold_neg  <= rot_neg;
      end
    end
  end

  // checks
  a_hold_needs_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_busy)
    else $error("waiting slot filled while drain slot empty");

  a_busy_has_event: assert property (@(posedge clk) disable iff (rst)
    out_busy |-> (out_mask != '0))
    else $error("drain slot busy with no pending event");

  a_event_reaches_out: assert property (@(posedge clk) disable iff (rst)
    new_item |=> out_busy)
    else $error("accepted tick with events left output idle");

  a_press_release_apart: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !(press && release_ev))
    else $error("press and release in one tick");

endmodule

[verif/gesture_sb_pkg.sv]
// ----------------------------------------------------------------------------
// gesture_sb_pkg: event predictor and scoreboard for the gesture qualifier
// Keeps its own copy of the settings and of the decoder state, works out the
// events of each accepted tick and checks the delivered events in order.
// ----------------------------------------------------------------------------
package gesture_sb_pkg;
  import ebgq_pkg::*;

  typedef logic [TIME_WIDTH_DEFAULT-1:0] tick_t;

  // one delivered event word
  typedef struct packed {
    event_kind_t       kind;
    logic signed [1:0] dir;
    logic              last_flag;
  } gesture_event_t;

  class gesture_scoreboard;
    // settings
    logic [2:0] detent_steps;
    tick_t      btn_lockout;
    tick_t      vib_lockout;
    tick_t      long_ticks;
    tick_t      click_gap;
    tick_t      vib_window;
    logic [3:0] vib_needed;

    // decoder state
    logic [1:0] last_phase;
    int         accum;
    tick_t      tick_now;
    logic       last_btn;
    tick_t      btn_accept;
    logic       held;
    tick_t      press_start;
    logic       long_done;
    tick_t      last_click;
    int         clicks;
    logic       last_vib;
    tick_t      vib_accept;
    tick_t      window_start;
    int         vib_count;

    gesture_event_t pending_events[$];
    int mismatches;
    int ticks_taken;
    int events_checked;
    int kind_count[6];

    function new();
      detent_steps = RST_DETENT_STEPS;
      btn_lockout  = RST_BUTTON_LOCKOUT;
      vib_lockout  = RST_VIB_LOCKOUT;
      long_ticks   = RST_LONG_PRESS;
      click_gap    = RST_CLICK_INTERVAL;
      vib_window   = RST_VIB_WINDOW;
      vib_needed   = RST_VIB_COUNT;
      last_phase   = 2'b11;
      accum        = 0;
      tick_now     = '0;
      last_btn     = 1'b1;
      btn_accept   = '0;
      held         = 1'b0;
      press_start  = '0;
      long_done    = 1'b0;
      last_click   = '0;
      clicks       = 0;
      last_vib     = 1'b1;
      vib_accept   = '0;
      window_start = '0;
      vib_count    = 0;
      mismatches   = 0;
      ticks_taken  = 0;
      events_checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] value);
      case (idx)
        REG_DETENT_STEPS:   detent_steps = value[2:0];
        REG_BUTTON_LOCKOUT: btn_lockout  = value;
        REG_VIB_LOCKOUT:    vib_lockout  = value;
        REG_LONG_PRESS:     long_ticks   = value;
        REG_CLICK_INTERVAL: click_gap    = value;
        REG_VIB_WINDOW:     vib_window   = value;
        REG_VIB_COUNT:      vib_needed   = value[3:0];
        default: ;
      endcase
    endfunction

    // ticks since a stored time, wrapping with the counter
    function tick_t since(tick_t then_t);
      return tick_now - then_t;
    endfunction

    // quadrature step from the gray position of both phase pairs
    function int phase_delta(logic [1:0] from_ab, logic [1:0] to_ab);
      logic [1:0] d;
      d = {to_ab[1], ^to_ab} - {from_ab[1], ^from_ab};
      if (d == 2'd1) return -1;
      if (d == 2'd3) return 1;
      return 0;
    endfunction

    function void add_event(event_kind_t kind, logic signed [1:0] dir);
      gesture_event_t ev;
      ev.kind      = kind;
      ev.dir       = dir;
      ev.last_flag = 1'b0;
      pending_events.push_back(ev);
    endfunction

    // work out the events of one accepted tick
    function void predict_tick(logic a, logic b, logic btn, logic vib);
      int limit;
      int need;
      int queued;
      queued = pending_events.size();
      ticks_taken++;

      // encoder detents
      limit = (detent_steps == 0) ? 1 : int'(detent_steps);
      accum += phase_delta(last_phase, {a, b});
      last_phase = {a, b};
      if (accum >= limit) begin
        add_event(EV_ROTATE, -2'sd1);
        accum = 0;
      end else if (accum <= -limit) begin
        add_event(EV_ROTATE, 2'sd1);
        accum = 0;
      end

      // press and triple click
      if (last_btn && !btn && since(btn_accept) >= btn_lockout) begin
        btn_accept  = tick_now;
        held        = 1'b1;
        press_start = tick_now;
        long_done   = 1'b0;
        add_event(EV_PRESS, 2'sd0);
        if (since(last_click) < click_gap) begin
          clicks++;
          if (clicks >= 3) begin
            add_event(EV_TRIPLE, 2'sd0);
            clicks = 0;
          end
        end else begin
          clicks = 1;
        end
        last_click = tick_now;
      end
      last_btn = btn;

      // release
      if (held && btn) begin
        held = 1'b0;
        add_event(EV_RELEASE, 2'sd0);
      end

      // long press
      if (held && !long_done && since(press_start) >= long_ticks) begin
        long_done = 1'b1;
        add_event(EV_LONG, 2'sd0);
      end

      // vibration triggers within the window
      if (last_vib && !vib && since(vib_accept) >= vib_lockout) begin
        need = (vib_needed == 0) ? 1 : int'(vib_needed);
        vib_accept = tick_now;
        if (vib_count > 0 && since(window_start) > vib_window) vib_count = 0;
        if (vib_count == 0) begin
          window_start = tick_now;
          vib_count    = 1;
        end else begin
          vib_count++;
        end
        if (vib_count >= need) begin
          vib_count = 0;
          add_event(EV_VIB, 2'sd0);
        end
      end
      last_vib = vib;

      if (pending_events.size() > queued)
        pending_events[pending_events.size()-1].last_flag = 1'b1;
      tick_now++;
    endfunction

    // compare one delivered word with the oldest expectation
    function void check_event(event_kind_t kind, logic signed [1:0] dir, logic last_flag);
      gesture_event_t want;
      events_checked++;
      if (!$isunknown(kind) && kind <= EV_VIB) kind_count[int'(kind)]++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event kind %0d dir %0d last %0d arrived with nothing expected",
                   kind, dir, last_flag);
        return;
      end
      want = pending_events.pop_front();
      if (want.kind !== kind || want.dir !== dir || want.last_flag !== last_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch on event %0d: expected kind %0d dir %0d last %0d, ",
                    "got kind %0d dir %0d last %0d"},
                   events_checked, want.kind, want.dir, want.last_flag, kind, dir, last_flag);
      end
    endfunction
  endclass

endpackage

[verif/encoder_button_gesture_qualifier_tb.sv]
// ----------------------------------------------------------------------------
// encoder_button_gesture_qualifier_tb: stream test of the gesture qualifier
// Drives pin ticks under several register settings, starting with directed
// detents, early-edge lockout, zero settings and a tick with five events, then
// well-formed gray walks and button/vibration runs with some noise. Both
// channels idle at random; every event word is checked against a predictor.
// ----------------------------------------------------------------------------
module encoder_button_gesture_qualifier_tb;
  import ebgq_pkg::*;
  import gesture_sb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REG_UNUSED  = 7;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  ebgq_in_if  in_ch ();
  ebgq_out_if out_ch ();

  encoder_button_gesture_qualifier dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gesture_scoreboard sb;
  bit   no_idle = 1'b0;
  int   next_gap = 0;
  int   sink_hold = 0;
  int   stall_draw;
  int   cycle_count = 0;
  int   settings_used = 1;

  // pin levels of the last tick sent
  logic       enc_a = 1'b1;
  logic       enc_b = 1'b1;
  logic [1:0] enc_dir = 2'd1;
  logic       btn_lvl = 1'b1;
  logic       vib_lvl = 1'b1;
  int         btn_run = 0;
  int         vib_run = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 5));
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still expected",
               cycle_count, sb.pending_events.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // event sink with random stalls after each word
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (out_ch.ready) begin
      if (out_ch.valid) begin
        stall_draw = draw_wait();
        out_ch.ready <= (stall_draw == 0);
        sink_hold    <= stall_draw;
      end
    end else begin
      if (sink_hold <= 1) out_ch.ready <= 1'b1;
      sink_hold <= sink_hold - 1;
    end
  end

  // monitor: predict on accepted ticks, check accepted event words
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.predict_tick(in_ch.phase_a, in_ch.phase_b, in_ch.button_level,
                        in_ch.vibration_level);
      if (out_ch.valid && out_ch.ready)
        sb.check_event(out_ch.event_kind, out_ch.rotate_step, out_ch.last_of_tick);
    end
  end

  // one tick word; valid stays high when the next word follows at once
  task automatic send_tick(input logic a, input logic b, input logic btn, input logic vib);
    repeat (next_gap) @(posedge clk);
    in_ch.valid           <= 1'b1;
    in_ch.phase_a         <= a;
    in_ch.phase_b         <= b;
    in_ch.button_level    <= btn;
    in_ch.vibration_level <= vib;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    next_gap = draw_wait();
    if (next_gap != 0) in_ch.valid <= 1'b0;
    enc_a   = a;
    enc_b   = b;
    btn_lvl = btn;
    vib_lvl = vib;
  endtask

  task automatic stop_ticks();
    if (next_gap == 0) in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every expected event has come
  task automatic drain();
    stop_ticks();
    while (sb.pending_events.size() != 0) @(posedge clk);
  endtask

  // idle point for register writes
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup and access cycle
  task automatic write_reg(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] detent, input logic [31:0] btn_lock,
                                input logic [31:0] vib_lock, input logic [31:0] long_hold,
                                input logic [31:0] click_iv, input logic [31:0] window,
                                input logic [31:0] needed);
    write_reg(REG_DETENT_STEPS, detent);
    write_reg(REG_BUTTON_LOCKOUT, btn_lock);
    write_reg(REG_VIB_LOCKOUT, vib_lock);
    write_reg(REG_LONG_PRESS, long_hold);
    write_reg(REG_CLICK_INTERVAL, click_iv);
    write_reg(REG_VIB_WINDOW, window);
    write_reg(REG_VIB_COUNT, needed);
    settings_used++;
  endtask

  // gray walks with button and vibration runs, some noise ticks
  task automatic random_ticks(input int count);
    logic [1:0] pos;
    logic       a;
    logic       b;
    logic       btn;
    logic       vib;
    for (int i = 0; i < count; i++) begin
      if (i % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
      btn = btn_lvl;
      vib = vib_lvl;
      if ($urandom_range(0, 99) < 8) begin
        // noise: every pin random
        {a, b, btn, vib} = 4'($urandom);
      end else begin
        pos = {enc_a, enc_a ^ enc_b};
        if ($urandom_range(0, 15) == 0) enc_dir = -enc_dir;
        case ($urandom_range(0, 9))
          0, 1, 2: ;
          9:       pos = pos + 2'd2;
          default: pos = pos + enc_dir;
        endcase
        a = pos[1];
        b = pos[1] ^ pos[0];
        if (btn_run == 0) begin
          btn     = !btn;
          btn_run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6);
        end else begin
          btn_run--;
        end
        if (vib_run == 0) begin
          vib     = !vib;
          vib_run = $urandom_range(1, 6);
        end else begin
          vib_run--;
        end
      end
      send_tick(a, b, btn, vib);
      if ($urandom_range(0, 39) == 0) drain();
    end
  endtask

  initial begin
    // {phase_a, phase_b, button, vibration}
    logic [3:0] reset_ticks [9] = '{4'b1111, 4'b0101, 4'b0010, 4'b1011, 4'b1111,
                                    4'b1011, 4'b0011, 4'b0111, 4'b1111};
    logic [3:0] burst_ticks [7] = '{4'b0101, 4'b0111, 4'b0000, 4'b0011,
                                    4'b1000, 4'b1011, 4'b1011};
    sb = new();
    rst                   = 1'b1;
    in_ch.valid           = 1'b0;
    in_ch.phase_a         = 1'b1;
    in_ch.phase_b         = 1'b1;
    in_ch.button_level    = 1'b1;
    in_ch.vibration_level = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: edges inside the first lockout, one detent each way
    foreach (reset_ticks[i])
      send_tick(reset_ticks[i][3], reset_ticks[i][2], reset_ticks[i][1], reset_ticks[i][0]);

    // single-step detents, no lockouts, zero long press, five events in one tick
    settle();
    apply_settings(1, 0, 0, 0, 10, 20, 1);
    write_reg(REG_UNUSED, 32'h0000_0005);
    foreach (burst_ticks[i])
      send_tick(burst_ticks[i][3], burst_ticks[i][2], burst_ticks[i][1], burst_ticks[i][0]);

    // zero detent and zero threshold act as one
    settle();
    write_reg(REG_DETENT_STEPS, 0);
    write_reg(REG_VIB_COUNT, 0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1);

    // random phases: moderate, widest limits, full lockout, then random settings
    settle();
    apply_settings(4, 2, 1, 6, 8, 15, 3);
    random_ticks(68);
    settle();
    apply_settings(7, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15);
    random_ticks(68);
    settle();
    apply_settings(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1);
    random_ticks(68);
    repeat (3) begin
      settle();
      apply_settings($urandom_range(0, 7), $urandom_range(0, 10), $urandom_range(0, 10),
                     $urandom_range(0, 25), $urandom_range(0, 30), $urandom_range(0, 50),
                     $urandom_range(0, 15));
      random_ticks(68);
    end
    settle();

    $display("ran %0d ticks under %0d register settings, %0d event words checked, %0d mismatches",
             sb.ticks_taken, settings_used, sb.events_checked, sb.mismatches);
    $display("events seen: rotate %0d press %0d release %0d long %0d triple %0d vibration %0d",
             sb.kind_count[EV_ROTATE], sb.kind_count[EV_PRESS], sb.kind_count[EV_RELEASE],
             sb.kind_count[EV_LONG], sb.kind_count[EV_TRIPLE], sb.kind_count[EV_VIB]);
    if (sb.mismatches == 0 && sb.pending_events.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
design/ebgq_pkg.sv
design/ebgq_if.sv
design/encoder_button_gesture_qualifier.sv
verif/gesture_sb_pkg.sv
verif/encoder_button_gesture_qualifier_tb.sv
